### rtl/sha1md_pkg.sv
// Shared types and constants for the SHA-1 message digest block.
// Used by sha1md_front, sha1md_back and sha1_message_digest; no dependencies.
`default_nettype none

package sha1md_pkg;

   // One queued request as the front part hands it to the back part.
   typedef struct packed {
      logic [7:0] data_byte;
      logic       byte_present;
      logic       end_of_message;
   } item_type;

   typedef logic [4:0][31:0] words5_type;

   localparam logic [31:0] H0_INIT = 32'h67452301;
   localparam logic [31:0] H1_INIT = 32'hEFCDAB89;
   localparam logic [31:0] H2_INIT = 32'h98BADCFE;
   localparam logic [31:0] H3_INIT = 32'h10325476;
   localparam logic [31:0] H4_INIT = 32'hC3D2E1F0;

   localparam logic [31:0] K_ROUND0 = 32'h5A827999;
   localparam logic [31:0] K_ROUND1 = 32'h6ED9EBA1;
   localparam logic [31:0] K_ROUND2 = 32'h8F1BBCDC;
   localparam logic [31:0] K_ROUND3 = 32'hCA62C1D6;

   localparam logic [7:0] PAD_MARKER = 8'h80;

   localparam words5_type CHAIN_INIT = {H4_INIT, H3_INIT, H2_INIT, H1_INIT, H0_INIT};

endpackage

`default_nettype wire

### rtl/sha1md_front.sv
// Front part of the SHA-1 digest block: accepts requests, drops empty ones
// and queues the rest for the back part. Depends on sha1md_pkg.
`default_nettype none

module sha1md_front (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire logic [7:0]          req_data_byte,
   input  wire logic                req_byte_present,
   input  wire logic                req_end_of_message,
   output logic                     q_valid,
   output sha1md_pkg::item_type     q_item,
   input  wire logic                q_pop
);
   import sha1md_pkg::*;

   localparam int QUEUE_DEPTH = 4;

   item_type   queue_ff [QUEUE_DEPTH];
   logic [1:0] wr_ptr_ff, wr_ptr_in;
   logic [1:0] rd_ptr_ff, rd_ptr_in;
   logic [2:0] count_ff, count_in;
   logic       push;
   logic       pop;

   assign req_stall = (count_ff == 3'(QUEUE_DEPTH));
   // A request with neither a byte nor an end flag changes nothing; it is taken and dropped.
   assign push = req_valid && !req_stall && (req_byte_present || req_end_of_message);
   assign pop  = q_pop && q_valid;

   assign q_valid = (count_ff != 3'd0);
   assign q_item  = queue_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 2'd1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 2'd1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 3'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 2'd0;
         rd_ptr_ff <= 2'd0;
         count_ff  <= 3'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= '{data_byte:      req_data_byte,
                                  byte_present:   req_byte_present,
                                  end_of_message: req_end_of_message};
      end
   end

endmodule

`default_nettype wire

### rtl/sha1md_back.sv
// Back part of the SHA-1 digest block: block assembly, padding, the 80-round
// compression, chaining update and digest output. Depends on sha1md_pkg.
`default_nettype none

module sha1md_back #(
   parameter int LENGTH_COUNTER_BITS = 64
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                q_valid,
   input  wire sha1md_pkg::item_type q_item,
   output logic                     q_pop,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output logic [31:0]              rsp_digest_word,
   output logic [2:0]               rsp_word_index,
   output logic                     rsp_last_word
);
   import sha1md_pkg::*;

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_PAD   = 5'b00010,
      ST_ROUND = 5'b00100,
      ST_FOLD  = 5'b01000,
      ST_EMIT  = 5'b10000
   } state_type;

   state_type  state_ff, state_in;
   // Message block and schedule share one shift line; word 0 sits in the top bits.
   logic [511:0] blk_ff, blk_in;
   logic [5:0]   pos_ff, pos_in;
   logic [LENGTH_COUNTER_BITS-1:0] len_cnt_ff, len_cnt_in;
   logic [63:0]  len_sh_ff, len_sh_in;
   logic         pad_act_ff, pad_act_in;
   logic         pad_first_ff, pad_first_in;
   logic         len_ok_ff, len_ok_in;
   logic         eom_pend_ff, eom_pend_in;
   logic [6:0]   rnd_ff, rnd_in;
   words5_type   vars_ff, vars_in;
   words5_type   chain_ff, chain_in;
   logic [2:0]   idx_ff, idx_in;
   logic         rsp_valid_ff, rsp_valid_in;
   logic [31:0]  rsp_word_ff, rsp_word_in;
   logic [2:0]   rsp_idx_ff, rsp_idx_in;
   logic         rsp_last_ff, rsp_last_in;

   logic         wr_en;
   logic [7:0]   wr_byte;
   logic [31:0]  w_cur, w_new, f_val, k_val, t_val;
   logic [31:0]  va, vb, vc, vd, ve;
   logic         out_free;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_digest_word = rsp_word_ff;
   assign rsp_word_index  = rsp_idx_ff;
   assign rsp_last_word   = rsp_last_ff;
   assign out_free        = !rsp_valid_ff || !rsp_stall;

   // Round datapath.
   always_comb begin
      va    = vars_ff[0];
      vb    = vars_ff[1];
      vc    = vars_ff[2];
      vd    = vars_ff[3];
      ve    = vars_ff[4];
      w_cur = blk_ff[511:480];
      w_new = blk_ff[511-32*13 -: 32] ^ blk_ff[511-32*8 -: 32]
            ^ blk_ff[511-32*2 -: 32] ^ blk_ff[511:480];
      w_new = {w_new[30:0], w_new[31]};
      if (rnd_ff < 7'd20) begin
         f_val = (vb & vc) | (~vb & vd);
         k_val = K_ROUND0;
      end else if (rnd_ff < 7'd40) begin
         f_val = vb ^ vc ^ vd;
         k_val = K_ROUND1;
      end else if (rnd_ff < 7'd60) begin
         f_val = (vb & vc) | (vb & vd) | (vc & vd);
         k_val = K_ROUND2;
      end else begin
         f_val = vb ^ vc ^ vd;
         k_val = K_ROUND3;
      end
      t_val = {va[26:0], va[31:27]} + f_val + ve + k_val + w_cur;
   end

   always_comb begin
      state_in     = state_ff;
      blk_in       = blk_ff;
      pos_in       = pos_ff;
      len_cnt_in   = len_cnt_ff;
      len_sh_in    = len_sh_ff;
      pad_act_in   = pad_act_ff;
      pad_first_in = pad_first_ff;
      len_ok_in    = len_ok_ff;
      eom_pend_in  = eom_pend_ff;
      rnd_in       = rnd_ff;
      vars_in      = vars_ff;
      chain_in     = chain_ff;
      idx_in       = idx_ff;
      rsp_valid_in = rsp_stall ? rsp_valid_ff : 1'b0;
      rsp_word_in  = rsp_word_ff;
      rsp_idx_in   = rsp_idx_ff;
      rsp_last_in  = rsp_last_ff;
      q_pop        = 1'b0;
      wr_en        = 1'b0;
      wr_byte      = 8'h00;

      case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               q_pop = 1'b1;
               if (q_item.byte_present) begin
                  wr_en      = 1'b1;
                  wr_byte    = q_item.data_byte;
                  len_cnt_in = len_cnt_ff + LENGTH_COUNTER_BITS'(8);
               end
               if (q_item.end_of_message) begin
                  len_sh_in = 64'(len_cnt_in);
                  if (q_item.byte_present && pos_ff == 6'd63) begin
                     // This byte closes a block; padding starts after it is compressed.
                     eom_pend_in = 1'b1;
                  end else begin
                     state_in     = ST_PAD;
                     pad_act_in   = 1'b1;
                     pad_first_in = 1'b1;
                     len_ok_in    = 1'b0;
                  end
               end
            end
         end
         ST_PAD: begin
            wr_en = 1'b1;
            if (pad_first_ff) begin
               wr_byte      = PAD_MARKER;
               pad_first_in = 1'b0;
               if (pos_ff[5:3] != 3'b111) begin
                  len_ok_in = 1'b1;
               end
            end else if (len_ok_ff && pos_ff[5:3] == 3'b111) begin
               wr_byte   = len_sh_ff[63:56];
               len_sh_in = {len_sh_ff[55:0], 8'h00};
            end
         end
         ST_ROUND: begin
            vars_in = {vd, vc, {vb[1:0], vb[31:2]}, va, t_val};
            blk_in  = {blk_ff[479:0], w_new};
            rnd_in  = rnd_ff + 7'd1;
            if (rnd_ff == 7'd79) begin
               state_in = ST_FOLD;
               rnd_in   = 7'd0;
            end
         end
         ST_FOLD: begin
            for (int j = 0; j < 5; j++) begin
               chain_in[j] = chain_ff[j] + vars_ff[j];
            end
            if (pad_act_ff) begin
               if (len_ok_ff) begin
                  state_in = ST_EMIT;
               end else begin
                  len_ok_in = 1'b1;
                  state_in  = ST_PAD;
               end
            end else if (eom_pend_ff) begin
               eom_pend_in  = 1'b0;
               pad_act_in   = 1'b1;
               pad_first_in = 1'b1;
               len_ok_in    = 1'b0;
               state_in     = ST_PAD;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_word_in  = chain_ff[idx_ff];
               rsp_idx_in   = idx_ff;
               rsp_last_in  = (idx_ff == 3'd4);
               idx_in       = idx_ff + 3'd1;
               if (idx_ff == 3'd4) begin
                  idx_in      = 3'd0;
                  chain_in    = CHAIN_INIT;
                  len_cnt_in  = '0;
                  pos_in      = 6'd0;
                  pad_act_in  = 1'b0;
                  eom_pend_in = 1'b0;
                  state_in    = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // Message and padding bytes enter the block the same way.
      if (wr_en) begin
         blk_in = {blk_ff[503:0], wr_byte};
         pos_in = pos_ff + 6'd1;
         if (pos_ff == 6'd63) begin
            state_in = ST_ROUND;
            rnd_in   = 7'd0;
            vars_in  = chain_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pos_ff       <= 6'd0;
         len_cnt_ff   <= '0;
         pad_act_ff   <= 1'b0;
         pad_first_ff <= 1'b0;
         len_ok_ff    <= 1'b0;
         eom_pend_ff  <= 1'b0;
         rnd_ff       <= 7'd0;
         chain_ff     <= CHAIN_INIT;
         idx_ff       <= 3'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         len_cnt_ff   <= len_cnt_in;
         pad_act_ff   <= pad_act_in;
         pad_first_ff <= pad_first_in;
         len_ok_ff    <= len_ok_in;
         eom_pend_ff  <= eom_pend_in;
         rnd_ff       <= rnd_in;
         chain_ff     <= chain_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      blk_ff      <= blk_in;
      len_sh_ff   <= len_sh_in;
      vars_ff     <= vars_in;
      rsp_word_ff <= rsp_word_in;
      rsp_idx_ff  <= rsp_idx_in;
      rsp_last_ff <= rsp_last_in;
   end

endmodule

`default_nettype wire

### rtl/sha1_message_digest.sv
// Top level of the SHA-1 message digest block: joins the request queue and the
// hashing engine. Depends on sha1md_pkg, sha1md_front and sha1md_back.
`default_nettype none

// SHA-1 over a byte stream, one byte per request, with an end-of-message flag;
// after the last request the five digest words come out H0 first, and the
// block then starts a fresh message. Requests land in a four-entry queue, so
// bytes keep arriving while a block is compressed. The hashing engine takes
// one byte per cycle while it is idle, runs the 80 rounds on one shared round
// unit, one round a cycle, and then folds the result into the chaining value.
// End of message adds the padding bytes at one a cycle (up to two blocks
// with their rounds), then hands out the five digest words, which wait while
// the output stalls.
module sha1_message_digest #(
   parameter int LENGTH_COUNTER_BITS = 64
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_data_byte,
   input  wire logic        req_byte_present,
   input  wire logic        req_end_of_message,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [31:0]      rsp_digest_word,
   output logic [2:0]       rsp_word_index,
   output logic             rsp_last_word
);
   import sha1md_pkg::*;

   logic     q_valid;
   item_type q_item;
   logic     q_pop;

   sha1md_front u_front (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_data_byte      (req_data_byte),
      .req_byte_present   (req_byte_present),
      .req_end_of_message (req_end_of_message),
      .q_valid            (q_valid),
      .q_item             (q_item),
      .q_pop              (q_pop)
   );

   sha1md_back #(
      .LENGTH_COUNTER_BITS (LENGTH_COUNTER_BITS)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .q_valid         (q_valid),
      .q_item          (q_item),
      .q_pop           (q_pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_digest_word (rsp_digest_word),
      .rsp_word_index  (rsp_word_index),
      .rsp_last_word   (rsp_last_word)
   );

endmodule

`default_nettype wire

### tb/tb_sha1_message_digest.sv
// Self-checking testbench for sha1_message_digest: byte requests with random gaps
// and output stalls, digest words checked against an in-bench SHA-1 predictor.
// Depends on sha1md_pkg and the RTL of sha1_message_digest.
`timescale 1ns / 1ps

module tb_sha1_message_digest;
   import sha1md_pkg::*;

   localparam int ITEM_TARGET    = 270;
   localparam int STALL_LIMIT    = 4000;
   localparam int SETTLE_CYCLES  = 400;
   localparam int LONG_HOLD      = 500;

   typedef struct {
      logic [31:0] word;
      logic [2:0]  index;
      logic        last_flag;
   } digest_rec_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_data_byte = 8'h00;
   logic        req_byte_present = 1'b0;
   logic        req_end_of_message = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [31:0] rsp_digest_word;
   logic [2:0]  rsp_word_index;
   logic        rsp_last_word;

   // Predictor state.
   logic [31:0] chain_words [5];
   logic [7:0]  msg_block [64];
   logic [63:0] msg_bit_count;
   digest_rec_type pending_digest_words [$];

   int  error_count = 0;
   int  requests_sent = 0;
   bit  tx_burst = 1'b0;
   bit  rx_burst = 1'b0;
   int  rx_hold_left = 0;

   sha1_message_digest #(
      .LENGTH_COUNTER_BITS(64)
   ) u_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_data_byte      (req_data_byte),
      .req_byte_present   (req_byte_present),
      .req_end_of_message (req_end_of_message),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_digest_word    (rsp_digest_word),
      .rsp_word_index     (rsp_word_index),
      .rsp_last_word      (rsp_last_word)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   function automatic void start_new_message();
      int j;
      for (j = 0; j < 5; j++) chain_words[j] = CHAIN_INIT[j];
      msg_bit_count = '0;
   endfunction

   function automatic void compress_block();
      logic [31:0] w [16];
      logic [31:0] a, b, c, d, e, f, k, t, x;
      int          r, j, slot;
      for (j = 0; j < 16; j++) begin
         w[j] = {msg_block[4*j], msg_block[4*j+1], msg_block[4*j+2], msg_block[4*j+3]};
      end
      a = chain_words[0];
      b = chain_words[1];
      c = chain_words[2];
      d = chain_words[3];
      e = chain_words[4];
      for (r = 0; r < 80; r++) begin
         slot = r & 15;
         if (r >= 16) begin
            x = w[(r+13) & 15] ^ w[(r+8) & 15] ^ w[(r+2) & 15] ^ w[slot];
            w[slot] = {x[30:0], x[31]};
         end
         if (r < 20) begin
            f = (b & c) | (~b & d);
            k = K_ROUND0;
         end else if (r < 40) begin
            f = b ^ c ^ d;
            k = K_ROUND1;
         end else if (r < 60) begin
            f = (b & c) | (b & d) | (c & d);
            k = K_ROUND2;
         end else begin
            f = b ^ c ^ d;
            k = K_ROUND3;
         end
         t = {a[26:0], a[31:27]} + f + e + k + w[slot];
         e = d;
         d = c;
         c = {b[1:0], b[31:2]};
         b = a;
         a = t;
      end
      chain_words[0] += a;
      chain_words[1] += b;
      chain_words[2] += c;
      chain_words[3] += d;
      chain_words[4] += e;
   endfunction

   // Applies one accepted request to the predictor and queues any digest words.
   function automatic void absorb_request(logic [7:0] data, logic present, logic eom);
      logic [5:0]  pos;
      logic [63:0] msg_bits;
      digest_rec_type rec;
      int          j;
      if (present) begin
         pos = msg_bit_count[8:3];
         msg_block[pos] = data;
         msg_bit_count += 64'd8;
         if (pos == 6'd63) compress_block();
      end
      if (!eom) return;
      pos = msg_bit_count[8:3];
      msg_bits = msg_bit_count;
      msg_block[pos] = PAD_MARKER;
      for (j = int'(pos) + 1; j < 64; j++) msg_block[j] = 8'h00;
      // A tail longer than 55 bytes leaves no room for the length field.
      if (pos > 6'd55) begin
         compress_block();
         for (j = 0; j < 64; j++) msg_block[j] = 8'h00;
      end
      for (j = 0; j < 8; j++) msg_block[63-j] = msg_bits[8*j +: 8];
      compress_block();
      for (j = 0; j < 5; j++) begin
         rec.word = chain_words[j];
         rec.index = j[2:0];
         rec.last_flag = (j == 4);
         pending_digest_words.push_back(rec);
      end
      start_new_message();
   endfunction

   task automatic send_request(input logic [7:0] data, input logic present, input logic eom);
      int gap;
      gap = tx_burst ? 0 : $urandom_range(0, 19);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_data_byte      <= data;
      req_byte_present   <= present;
      req_end_of_message <= eom;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      absorb_request(data, present, eom);
      if (present || eom) requests_sent++;
   endtask

   // Sends one message of random content; the end flag rides on the last byte
   // or on a separate request without a byte. Noise sprinkles in empty requests.
   task automatic send_message(input int len, input bit eom_on_byte, input bit noise);
      int i;
      for (i = 0; i < len; i++) begin
         if (noise && $urandom_range(0, 9) == 0) begin
            send_request(8'($urandom_range(0, 255)), 1'b0, 1'b0);
         end
         send_request(8'($urandom_range(0, 255)), 1'b1, eom_on_byte && (i == len - 1));
      end
      if (len == 0 || !eom_on_byte) send_request(8'($urandom_range(0, 255)), 1'b0, 1'b1);
   endtask

   task automatic wait_for_digests();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_digest_words.size() != 0) @(posedge clock);
   endtask

   task automatic test_empty_cases();
      send_request(8'hA5, 1'b0, 1'b0);
      send_request(8'h5A, 1'b0, 1'b1);
      send_request(8'hFF, 1'b0, 1'b0);
      send_request(8'h00, 1'b0, 1'b1);
   endtask

   task automatic test_short_messages();
      send_request(8'h61, 1'b1, 1'b0);
      send_request(8'h62, 1'b1, 1'b0);
      send_request(8'h00, 1'b0, 1'b0);
      send_request(8'h63, 1'b1, 1'b1);
      send_request(8'hFF, 1'b1, 1'b0);
      send_request(8'h00, 1'b0, 1'b1);
      send_request(8'h00, 1'b1, 1'b1);
      send_request(8'hFF, 1'b1, 1'b1);
   endtask

   // Lengths that put the padding just inside, just past and at a block edge.
   task automatic test_block_boundaries();
      send_message(55, 1'b1, 1'b0);
      send_message(56, 1'b0, 1'b0);
      send_message(64, 1'b1, 1'b0);
   endtask

   task automatic test_output_backpressure();
      int m;
      rx_hold_left = LONG_HOLD;
      tx_burst = 1'b1;
      for (m = 0; m < 4; m++) send_message(3, 1'b1, 1'b0);
      tx_burst = 1'b0;
   endtask

   task automatic test_pause_for_digests();
      send_message(5, 1'b1, 1'b0);
      wait_for_digests();
      send_message(2, 1'b0, 1'b0);
   endtask

   task automatic test_random_messages();
      int len, pick;
      while (requests_sent < ITEM_TARGET) begin
         tx_burst = ($urandom_range(0, 4) == 0);
         rx_burst = ($urandom_range(0, 4) == 0);
         pick = $urandom_range(0, 99);
         if (pick < 65) begin
            len = $urandom_range(0, 12);
         end else if (pick < 85) begin
            case ($urandom_range(0, 5))
               0: len = 55;
               1: len = 56;
               2: len = 57;
               3: len = 63;
               4: len = 64;
               default: len = 65;
            endcase
         end else begin
            len = $urandom_range(0, 130);
         end
         // Keeps the request count close to the target.
         if (len > ITEM_TARGET - requests_sent) len = ITEM_TARGET - requests_sent;
         send_message(len, 1'($urandom_range(0, 1)), 1'b1);
         if ($urandom_range(0, 7) == 0) wait_for_digests();
      end
      tx_burst = 1'b0;
      rx_burst = 1'b0;
   endtask

   // Result side: checks every accepted digest word and draws its own stalls.
   initial begin
      digest_rec_type exp_rec;
      int          rx_wait_left;
      rx_wait_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            if (pending_digest_words.size() == 0) begin
               $display("%0t: unexpected digest word %h index %0d", $time,
                        rsp_digest_word, rsp_word_index);
               error_count++;
            end else begin
               exp_rec = pending_digest_words.pop_front();
               if (rsp_digest_word !== exp_rec.word) begin
                  $display("%0t: digest_word expected %h actual %h", $time,
                           exp_rec.word, rsp_digest_word);
                  error_count++;
               end
               if (rsp_word_index !== exp_rec.index) begin
                  $display("%0t: word_index expected %0d actual %0d", $time,
                           exp_rec.index, rsp_word_index);
                  error_count++;
               end
               if (rsp_last_word !== exp_rec.last_flag) begin
                  $display("%0t: last_word expected %0d actual %0d", $time,
                           exp_rec.last_flag, rsp_last_word);
                  error_count++;
               end
            end
            rx_wait_left = rx_burst ? 0 : $urandom_range(0, 19);
         end
         if (rx_hold_left > 0) begin
            rx_hold_left--;
            rsp_stall <= 1'b1;
         end else if (rx_wait_left > 0) begin
            rx_wait_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Ends the run when neither channel has moved for too long.
   initial begin
      int quiet_cycles;
      quiet_cycles = 0;
      forever begin
         @(posedge clock);
         if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("sha1_message_digest test failed");
            $finish;
         end
      end
   end

   initial begin
      start_new_message();
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      test_empty_cases();
      test_short_messages();
      test_block_boundaries();
      test_output_backpressure();
      test_pause_for_digests();
      test_random_messages();
      wait_for_digests();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0 && pending_digest_words.size() == 0) begin
         $display("sha1_message_digest test passed");
      end else begin
         $display("sha1_message_digest test failed");
      end
      $finish;
   end

endmodule

### sha1_message_digest.f
rtl/sha1md_pkg.sv
rtl/sha1md_front.sv
rtl/sha1md_back.sv
rtl/sha1_message_digest.sv
tb/tb_sha1_message_digest.sv
